// ===== sv/lzd_pkg.sv =====
// lzd_pkg: shared types and constants for the LZ77 stream decompressor.
// No dependencies; compiled first.
package lzd_pkg;

  localparam int WINDOW_DEPTH_DEF = 4096;
  localparam int LENGTH_BITS_DEF  = 24;

  // Token format
  localparam int MIN_MATCH   = 3;  // match length bias
  localparam int FLAG_TOKENS = 8;  // tokens governed by one flag byte
  localparam int LEN_W       = 5;  // holds up to 15 + MIN_MATCH
  localparam int DIST_W      = 13; // holds up to 4096

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       stream_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_done;
  } out_item_t;

endpackage

// ===== sv/lzd_stream_if.sv =====
// lzd_stream_if: valid/ready channel carrying one payload per transaction.
// Payload type is set per instance; used with lzd_pkg item types.
interface lzd_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/lzd_history.sv =====
// lzd_history: history window memory, one write and one registered read port.
// Forwards a byte written in the same cycle as a read of that entry.
module lzd_history
  import lzd_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int PW           = $clog2(WINDOW_DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [PW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [PW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [WINDOW_DEPTH];
  logic [7:0] rd_q;
  logic [7:0] fwd_q;
  logic       fwd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // read-during-write on the same entry returns the new byte
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (rd_en) begin
      fwd_hit <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_q <= wr_data;
    end
  end

  assign rd_data = fwd_hit ? fwd_q : rd_q;

endmodule

// ===== sv/lz77_stream_decompressor.sv =====
// lz77_stream_decompressor: LZSS decoder, 4-byte header, flag bytes, 12-bit distances.
// Header and flag bytes emit nothing; a literal shows at the output the cycle after its transaction.
// A match issues one history read, then one byte a cycle while the output is not stalled,
// paced by the read-then-write loop on the history memory; input is held off while the copy runs.
// Reset clears parse state, length and write pointer; the history memory is not cleared and holds
// whatever it held until written (no clearing pass).
module lz77_stream_decompressor
  import lzd_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int LENGTH_BITS  = LENGTH_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  lzd_stream_if.sink   stream_in,
  lzd_stream_if.source stream_out
);

  localparam int PW = $clog2(WINDOW_DEPTH);
  localparam int AW = PW + 1;
  localparam int LB = LENGTH_BITS;

  // parse phases
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_FLAG   = 3'd1;
  localparam logic [2:0] PH_TOKEN  = 3'd2;
  localparam logic [2:0] PH_MATCH2 = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  localparam logic [1:0] HDR_LAST = 2'd3;

  // ---------------------------------------------------------------
  // State
  // ---------------------------------------------------------------
  logic [2:0]    phase, phase_next;
  logic [1:0]    hdr_idx, hdr_idx_next;
  logic [LB-1:0] remaining, remaining_next;
  logic [7:0]    flag_bits, flag_bits_next;
  logic [3:0]    flag_count, flag_count_next;
  logic [7:0]    token_first, token_first_next;
  logic [PW-1:0] wp, wp_next;

  // copy engine
  logic             busy, busy_next;
  logic [LEN_W-1:0] copy_left, copy_left_next;
  logic [PW-1:0]    src, src_next;

  // output register
  logic       out_valid, out_valid_next;
  out_item_t  out_q, out_q_next;

  // history port
  logic          rd_en;
  logic [PW-1:0] rd_addr;
  logic [7:0]    hist_byte;
  logic          wr_en;
  logic [7:0]    wr_data;

  // ---------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------
  logic          slot_free;
  logic [2:0]    eff_phase;
  logic [1:0]    eff_idx;
  logic [7:0]    b;
  logic          lit;
  logic          in_acc;
  logic          copy_fire;
  logic [LB-1:0] rem_dec;
  logic          rem_zero;
  logic [PW-1:0] wp_inc;
  logic [PW-1:0] src_inc;
  logic [23:0]   hdr_word;
  logic [LB-1:0] hdr_rem;
  logic [DIST_W-1:0] back_dist;
  logic [AW-1:0] wp_ext;
  logic [AW-1:0] dist_ext;
  logic [AW-1:0] src_ext;
  logic [LEN_W-1:0] match_len;
  logic          copy_last;
  logic [7:0]    flag_shift;
  logic [3:0]    flag_dec;

  // slot is free when empty or being drained this cycle
  assign slot_free = !out_valid || stream_out.ready;

  // a start mark restarts the parse at header byte 0
  assign b         = stream_in.payload.stream_byte;
  assign eff_phase = stream_in.payload.stream_start ? PH_HEADER : phase;
  assign eff_idx   = stream_in.payload.stream_start ? 2'd0 : hdr_idx;
  assign lit       = (eff_phase == PH_TOKEN) && !flag_bits[7];

  // only a literal needs the output slot; other bytes are taken regardless
  assign stream_in.ready = !busy && (slot_free || !lit);
  assign in_acc    = stream_in.valid && stream_in.ready;
  assign copy_fire = busy && slot_free;

  assign rem_dec  = remaining - LB'(1);
  assign rem_zero = (rem_dec == '0);
  assign wp_inc   = (wp == PW'(WINDOW_DEPTH - 1)) ? '0 : wp + PW'(1);
  assign src_inc  = (src == PW'(WINDOW_DEPTH - 1)) ? '0 : src + PW'(1);

  // flag advance after a token
  assign flag_shift = {flag_bits[6:0], 1'b0};
  assign flag_dec   = flag_count - 4'd1;

  // header length bytes, little endian
  always_comb begin
    case (eff_idx)
      2'd1:    hdr_word = {16'd0, b};
      2'd2:    hdr_word = {8'd0, b, 8'd0};
      2'd3:    hdr_word = {b, 16'd0};
      default: hdr_word = '0;
    endcase
  end
  assign hdr_rem = remaining | hdr_word[LB-1:0];

  // match geometry from first and second token bytes
  assign match_len = {1'b0, token_first[7:4]} + LEN_W'(MIN_MATCH);
  assign back_dist = {1'b0, token_first[3:0], b} + DIST_W'(1);
  assign wp_ext    = {1'b0, wp};
  assign dist_ext  = AW'(back_dist);
  // wrap the back reference into the window
  assign src_ext   = (wp_ext >= dist_ext) ? (wp_ext - dist_ext)
                                          : (wp_ext + AW'(WINDOW_DEPTH) - dist_ext);

  assign copy_last = (copy_left == LEN_W'(1)) || rem_zero;

  // ---------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------
  always_comb begin
    phase_next       = phase;
    hdr_idx_next     = hdr_idx;
    remaining_next   = remaining;
    flag_bits_next   = flag_bits;
    flag_count_next  = flag_count;
    token_first_next = token_first;
    wp_next          = wp;
    busy_next        = busy;
    copy_left_next   = copy_left;
    src_next         = src;
    out_valid_next   = slot_free ? 1'b0 : out_valid;
    out_q_next       = out_q;
    rd_en            = 1'b0;
    rd_addr          = src_inc;
    wr_en            = 1'b0;
    wr_data          = hist_byte;

    if (copy_fire) begin
      // one match byte: emit, write back to history, fetch the next
      wr_en                  = 1'b1;
      wr_data                = hist_byte;
      out_valid_next         = 1'b1;
      out_q_next.out_byte    = hist_byte;
      out_q_next.run_last    = copy_last;
      out_q_next.stream_done = rem_zero;
      wp_next                = wp_inc;
      remaining_next         = rem_dec;
      copy_left_next         = copy_left - LEN_W'(1);
      if (copy_last) begin
        busy_next = 1'b0;
        if (rem_zero) begin
          phase_next = PH_DONE;
        end else begin
          flag_bits_next  = flag_shift;
          flag_count_next = flag_dec;
          phase_next      = (flag_dec == '0) ? PH_FLAG : PH_TOKEN;
        end
      end else begin
        rd_en    = 1'b1;
        rd_addr  = src_inc;
        src_next = src_inc;
      end
    end else if (in_acc) begin
      case (eff_phase)
        PH_HEADER: begin
          hdr_idx_next = eff_idx + 2'd1;
          if (eff_idx == '0) begin
            remaining_next = '0;
          end else begin
            remaining_next = hdr_rem;
          end
          if (eff_idx == HDR_LAST) begin
            phase_next = (hdr_rem == '0) ? PH_DONE : PH_FLAG;
          end else begin
            phase_next = PH_HEADER;
          end
        end
        PH_FLAG: begin
          flag_bits_next  = b;
          flag_count_next = 4'(FLAG_TOKENS);
          phase_next      = PH_TOKEN;
        end
        PH_TOKEN: begin
          if (flag_bits[7]) begin
            token_first_next = b;
            phase_next       = PH_MATCH2;
          end else begin
            // literal goes straight out and into history
            wr_en                  = 1'b1;
            wr_data                = b;
            out_valid_next         = 1'b1;
            out_q_next.out_byte    = b;
            out_q_next.run_last    = 1'b1;
            out_q_next.stream_done = rem_zero;
            wp_next                = wp_inc;
            remaining_next         = rem_dec;
            if (rem_zero) begin
              phase_next = PH_DONE;
            end else begin
              flag_bits_next  = flag_shift;
              flag_count_next = flag_dec;
              phase_next      = (flag_dec == '0) ? PH_FLAG : PH_TOKEN;
            end
          end
        end
        PH_MATCH2: begin
          // start the copy: first read issued now
          busy_next      = 1'b1;
          copy_left_next = match_len;
          src_next       = src_ext[PW-1:0];
          rd_en          = 1'b1;
          rd_addr        = src_ext[PW-1:0];
        end
        default: begin
          // done phase: bytes dropped until a start mark
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      hdr_idx     <= '0;
      remaining   <= '0;
      flag_bits   <= '0;
      flag_count  <= '0;
      token_first <= '0;
      wp          <= '0;
      busy        <= 1'b0;
      copy_left   <= '0;
      src         <= '0;
      out_valid   <= 1'b0;
    end else begin
      phase       <= phase_next;
      hdr_idx     <= hdr_idx_next;
      remaining   <= remaining_next;
      flag_bits   <= flag_bits_next;
      flag_count  <= flag_count_next;
      token_first <= token_first_next;
      wp          <= wp_next;
      busy        <= busy_next;
      copy_left   <= copy_left_next;
      src         <= src_next;
      out_valid   <= out_valid_next;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    out_q <= out_q_next;
  end

  assign stream_out.valid   = out_valid;
  assign stream_out.payload = out_q;

  // ---------------------------------------------------------------
  // History window
  // ---------------------------------------------------------------
  lzd_history #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .PW           (PW)
  ) u_history (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wp),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (hist_byte)
  );

endmodule
